[design/fit_policy_partition_allocator_unit_assert.svh]
// ----------------------------------------------------------------------------
// Fit-policy partition allocator assertion macros
// Shorthand for the concurrent checks used by the port checker.
// ----------------------------------------------------------------------------
`ifndef FIT_POLICY_PARTITION_ALLOCATOR_UNIT_ASSERT_SVH
`define FIT_POLICY_PARTITION_ALLOCATOR_UNIT_ASSERT_SVH

// same-cycle implication, off while reset is high
`define FPPA_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication, off while reset is high
`define FPPA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

[design/fppa_pkg.sv]
// ----------------------------------------------------------------------------
// Fit-policy partition allocator package
// Shared codes, defaults and the scan control word.
// ----------------------------------------------------------------------------
package fppa_pkg;

   localparam int MAX_PARTITIONS_DEF = 128;

   localparam int SIZE_W      = 16;
   localparam int PIDX_W      = 7;
   localparam int MODE_W      = 2;
   localparam int COUNT_W     = 8;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 8;

   // placement policies; the unused code falls back to first fit
   localparam logic [MODE_W-1:0] MODE_FIRST = 2'd0;
   localparam logic [MODE_W-1:0] MODE_BEST  = 2'd1;
   localparam logic [MODE_W-1:0] MODE_WORST = 2'd2;

   localparam logic CMD_LOAD  = 1'b0;
   localparam logic CMD_ALLOC = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_FIT_MODE   = 2'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_PART_COUNT = 2'd1;

   typedef struct packed {
      logic clear;    // start of a new scan
      logic sample;   // read data valid this cycle
   } pick_ctl_type;

endpackage

[design/fit_policy_partition_allocator_unit.sv]
// ----------------------------------------------------------------------------
// Fit-policy partition allocator
// Partition table with first, best and worst fit allocation.
// ----------------------------------------------------------------------------
// A load word writes one partition's remaining size and returns nothing. An
// allocate word scans partitions 0 .. count-1 through the table's single read
// port, one entry per cycle, into a shared compare unit, then charges the
// chosen partition if one fits and posts one result word. After an allocate is
// taken, req_stall stays high through the scan (partition_count, capped at
// MAX_PARTITIONS) and the finish step, so the block takes no new word until the
// allocate is through. The stall runs on while an earlier result word is still
// held by rsp_stall. The result register lets the next word in while a result
// still waits to be taken. The table holds no reset value: read only loaded
// entries.
// ----------------------------------------------------------------------------
module fit_policy_partition_allocator_unit
   import fppa_pkg::*;
#(
   parameter int MAX_PARTITIONS = MAX_PARTITIONS_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  logic                   req_cmd,
   input  logic [PIDX_W-1:0]      req_partition_index,
   input  logic [SIZE_W-1:0]      req_size_kb,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output logic                   rsp_granted,
   output logic [PIDX_W-1:0]      rsp_chosen_index,
   output logic [SIZE_W-1:0]      rsp_space_before,
   output logic [SIZE_W-1:0]      rsp_space_after,
   input  logic                   csr_write_enable,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_write_data
);

   localparam int ADDR_W = (MAX_PARTITIONS > 1) ? $clog2(MAX_PARTITIONS) : 1;
   localparam int CNT_W  = $clog2(MAX_PARTITIONS + 1);
   localparam int COUNT_RESET = (MAX_PARTITIONS > 128) ? 128 : MAX_PARTITIONS;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   // configuration
   logic [MODE_W-1:0]  fit_mode_ff;
   logic [COUNT_W-1:0] part_count_ff;

   // sequencer
   state_type          state_ff, state_in;
   logic [CNT_W-1:0]   cnt_ff, cnt_in;
   logic [CNT_W-1:0]   limit_ff, limit_in;
   logic [SIZE_W-1:0]  size_ff, size_in;
   logic               rd_vld_ff, rd_vld_in;
   logic [ADDR_W-1:0]  rd_idx_ff, rd_idx_in;

   // result register
   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_granted_ff, rsp_granted_in;
   logic [PIDX_W-1:0]  rsp_index_ff, rsp_index_in;
   logic [SIZE_W-1:0]  rsp_before_ff, rsp_before_in;
   logic [SIZE_W-1:0]  rsp_after_ff, rsp_after_in;

   // table
   logic [SIZE_W-1:0]  mem_ff [MAX_PARTITIONS];
   logic [SIZE_W-1:0]  rd_data_ff;
   logic               mem_we;
   logic [ADDR_W-1:0]  mem_wa;
   logic [SIZE_W-1:0]  mem_wd;

   logic               req_acc;
   logic               slot_free;
   logic               load_in_range;
   logic               scan_more;
   logic               finish_go;
   pick_ctl_type       pick_ctl;
   logic               pick_found;
   logic [ADDR_W-1:0]  pick_idx;
   logic [SIZE_W-1:0]  pick_val;
   logic [SIZE_W-1:0]  charged;

   fppa_pick #(
      .ADDR_W (ADDR_W)
   ) u_pick (
      .clock    (clock),
      .reset    (reset),
      .ctl      (pick_ctl),
      .mode     (fit_mode_ff),
      .req_size (size_ff),
      .rd_data  (rd_data_ff),
      .rd_idx   (rd_idx_ff),
      .found    (pick_found),
      .pick_idx (pick_idx),
      .pick_val (pick_val)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_mode_ff   <= MODE_FIRST;
         part_count_ff <= COUNT_W'(COUNT_RESET);
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_FIT_MODE:   fit_mode_ff   <= csr_write_data[MODE_W-1:0];
            CSR_PART_COUNT: part_count_ff <= csr_write_data[COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      req_stall     = (state_ff != ST_IDLE);
      req_acc       = req_valid && !req_stall;
      slot_free     = !rsp_valid_ff || !rsp_stall;
      load_in_range = (32'(req_partition_index) < 32'(MAX_PARTITIONS));
      scan_more     = (cnt_ff < limit_ff);
      finish_go     = (state_ff == ST_FINISH) && slot_free;
      charged       = pick_val - size_ff;

      pick_ctl.clear  = req_acc && (req_cmd == CMD_ALLOC);
      pick_ctl.sample = rd_vld_ff;

      mem_we = (req_acc && (req_cmd == CMD_LOAD) && load_in_range)
               || (finish_go && pick_found);
      mem_wa = (state_ff == ST_FINISH) ? pick_idx : ADDR_W'(req_partition_index);
      mem_wd = (state_ff == ST_FINISH) ? charged : req_size_kb;

      state_in  = state_ff;
      cnt_in    = cnt_ff;
      limit_in  = limit_ff;
      size_in   = size_ff;
      rd_vld_in = 1'b0;
      rd_idx_in = cnt_ff[ADDR_W-1:0];

      rsp_valid_in   = rsp_valid_ff && rsp_stall;
      rsp_granted_in = rsp_granted_ff;
      rsp_index_in   = rsp_index_ff;
      rsp_before_in  = rsp_before_ff;
      rsp_after_in   = rsp_after_ff;

      case (state_ff)
         ST_IDLE: begin
            if (req_acc && (req_cmd == CMD_ALLOC)) begin
               state_in = ST_SCAN;
               cnt_in   = '0;
               size_in  = req_size_kb;
               // cap the configured count at the table depth
               if (32'(part_count_ff) >= 32'(MAX_PARTITIONS)) begin
                  limit_in = CNT_W'(MAX_PARTITIONS);
               end else begin
                  limit_in = CNT_W'(part_count_ff);
               end
            end
         end
         ST_SCAN: begin
            if (scan_more) begin
               rd_vld_in = 1'b1;
               cnt_in    = cnt_ff + CNT_W'(1);
            end else if (!rd_vld_ff) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the result register is free
            if (slot_free) begin
               state_in       = ST_IDLE;
               rsp_valid_in   = 1'b1;
               rsp_granted_in = pick_found;
               rsp_index_in   = pick_found ? PIDX_W'(pick_idx) : '0;
               rsp_before_in  = pick_found ? pick_val : '0;
               rsp_after_in   = pick_found ? charged : '0;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_vld_ff    <= rd_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      cnt_ff         <= cnt_in;
      limit_ff       <= limit_in;
      size_ff        <= size_in;
      rd_idx_ff      <= rd_idx_in;
      rsp_granted_ff <= rsp_granted_in;
      rsp_index_ff   <= rsp_index_in;
      rsp_before_ff  <= rsp_before_in;
      rsp_after_ff   <= rsp_after_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[mem_wa] <= mem_wd;
      end
      rd_data_ff <= mem_ff[cnt_ff[ADDR_W-1:0]];
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted      = rsp_granted_ff;
   assign rsp_chosen_index = rsp_index_ff;
   assign rsp_space_before = rsp_before_ff;
   assign rsp_space_after  = rsp_after_ff;

endmodule

[design/fppa_pick.sv]
// ----------------------------------------------------------------------------
// Fit-policy partition allocator candidate picker
// Shared compare unit: looks at one table entry per cycle and keeps the
// current best candidate for the active placement policy.
// ----------------------------------------------------------------------------
module fppa_pick
   import fppa_pkg::*;
#(
   parameter int ADDR_W = 7
) (
   input  logic                    clock,
   input  logic                    reset,
   input  pick_ctl_type            ctl,
   input  logic [MODE_W-1:0]       mode,
   input  logic [SIZE_W-1:0]       req_size,
   input  logic [SIZE_W-1:0]       rd_data,
   input  logic [ADDR_W-1:0]       rd_idx,
   output logic                    found,
   output logic [ADDR_W-1:0]       pick_idx,
   output logic [SIZE_W-1:0]       pick_val
);

   logic              found_ff, found_in;
   logic [ADDR_W-1:0] pick_idx_ff, pick_idx_in;
   logic [SIZE_W-1:0] pick_val_ff, pick_val_in;
   logic              fits;
   logic              take;

   always_comb begin
      fits = (rd_data >= req_size);
      // strict compares keep the lowest index on ties
      take = fits && (!found_ff
                      || ((mode == MODE_BEST)  && (rd_data < pick_val_ff))
                      || ((mode == MODE_WORST) && (rd_data > pick_val_ff)));
      found_in    = found_ff;
      pick_idx_in = pick_idx_ff;
      pick_val_in = pick_val_ff;
      if (ctl.clear) begin
         found_in = 1'b0;
      end else if (ctl.sample && take) begin
         found_in    = 1'b1;
         pick_idx_in = rd_idx;
         pick_val_in = rd_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         found_ff <= 1'b0;
      end else begin
         found_ff <= found_in;
      end
      pick_idx_ff <= pick_idx_in;
      pick_val_ff <= pick_val_in;
   end

   assign found    = found_ff;
   assign pick_idx = pick_idx_ff;
   assign pick_val = pick_val_ff;

endmodule

[design/fppa_checker.sv]
// ----------------------------------------------------------------------------
// Fit-policy partition allocator port checker
// Watches the top level's ports and flags handshake and result slips.
// ----------------------------------------------------------------------------
`include "fit_policy_partition_allocator_unit_assert.svh"

module fppa_checker
   import fppa_pkg::*;
(
   input logic              clock,
   input logic              reset,
   input logic              req_valid,
   input logic              req_stall,
   input logic              req_cmd,
   input logic              rsp_valid,
   input logic              rsp_stall,
   input logic              rsp_granted,
   input logic [PIDX_W-1:0] rsp_chosen_index,
   input logic [SIZE_W-1:0] rsp_space_before,
   input logic [SIZE_W-1:0] rsp_space_after
);

   logic alloc_acc;
   logic refused_clean;

   assign alloc_acc     = req_valid && !req_stall && (req_cmd == CMD_ALLOC);
   assign refused_clean = (rsp_chosen_index == '0) && (rsp_space_before == '0)
                          && (rsp_space_after == '0);

   // a stalled result word stays offered
   `FPPA_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // an allocate keeps the block busy while it scans
   `FPPA_ASSERT_NEXT(a_alloc_busy, clock, reset, alloc_acc, req_stall)

   // a refusal reports nothing else
   `FPPA_ASSERT_NOW(a_refuse_zero, clock, reset, rsp_valid && !rsp_granted, refused_clean)

   // a grant never adds space
   `FPPA_ASSERT_NOW(a_grant_shrinks, clock, reset, rsp_valid && rsp_granted,
                    rsp_space_after <= rsp_space_before)

endmodule

bind fit_policy_partition_allocator_unit fppa_checker u_fppa_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .req_cmd          (req_cmd),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_granted      (rsp_granted),
   .rsp_chosen_index (rsp_chosen_index),
   .rsp_space_before (rsp_space_before),
   .rsp_space_after  (rsp_space_after)
);

[bench/fit_policy_partition_allocator_unit_test.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Fit-policy partition allocator testbench
// Loads partition sizes and issues allocate words under every placement
// policy and a range of partition counts. A scoreboard keeps its own copy of
// the partition table, predicts each grant or refusal and checks every result
// word in order. Both channels idle and stall at random.
// ----------------------------------------------------------------------------
package alloc_check_pkg;
   import fppa_pkg::*;

   localparam int MAX_PARTS = MAX_PARTITIONS_DEF;

   typedef struct packed {
      logic              granted;
      logic [PIDX_W-1:0] chosen_index;
      logic [SIZE_W-1:0] space_before;
      logic [SIZE_W-1:0] space_after;
   } grant_word_type;

   class alloc_scoreboard;
      logic [SIZE_W-1:0]  space [MAX_PARTS];
      logic [MODE_W-1:0]  mode;
      logic [COUNT_W-1:0] count;
      grant_word_type     awaited [$];
      int                 mismatches;

      function new();
         mode       = MODE_FIRST;
         count      = COUNT_W'(MAX_PARTS);
         mismatches = 0;
         foreach (space[i]) space[i] = '0;
      endfunction

      function void set_register(logic [CSR_INDEX_W-1:0] idx, logic [CSR_DATA_W-1:0] data);
         case (idx)
            CSR_FIT_MODE:   mode = data[MODE_W-1:0];
            CSR_PART_COUNT: count = data[COUNT_W-1:0];
            default: ;
         endcase
      endfunction

      // apply one accepted request word; allocates queue their grant word
      function void note_word(logic cmd, logic [PIDX_W-1:0] idx, logic [SIZE_W-1:0] kb);
         int             span;
         int             j;
         int             pick;
         bit             found;
         grant_word_type w;
         if (cmd == CMD_LOAD) begin
            space[idx] = kb;
            return;
         end
         span  = (int'(count) > MAX_PARTS) ? MAX_PARTS : int'(count);
         found = 1'b0;
         pick  = 0;
         for (j = 0; j < span; j++) begin
            if (space[j] < kb) continue;
            if (!found) begin
               found = 1'b1;
               pick  = j;
               // first fit, and the spare code, stop at the first hit
               if (mode != MODE_BEST && mode != MODE_WORST) break;
            end else if (mode == MODE_BEST && space[j] < space[pick]) begin
               pick = j;
            end else if (mode == MODE_WORST && space[j] > space[pick]) begin
               pick = j;
            end
         end
         w = '0;
         if (found) begin
            w.granted      = 1'b1;
            w.chosen_index = pick[PIDX_W-1:0];
            w.space_before = space[pick];
            w.space_after  = space[pick] - kb;
            space[pick]    = w.space_after;
         end
         awaited.push_back(w);
      endfunction

      // fields shown as granted/index/space before/space after
      function void report(string what, grant_word_type want, grant_word_type got);
         mismatches++;
         if (mismatches <= 10)
            $display("%s: expected %0b/%0d/%0d/%0d, got %0b/%0d/%0d/%0d", what,
                     want.granted, want.chosen_index, want.space_before, want.space_after,
                     got.granted, got.chosen_index, got.space_before, got.space_after);
      endfunction

      function void check_result(grant_word_type got);
         grant_word_type want;
         if (awaited.size() == 0) begin
            report("unexpected result word", '0, got);
            return;
         end
         want = awaited.pop_front();
         if (got.granted !== want.granted || got.chosen_index !== want.chosen_index ||
             got.space_before !== want.space_before || got.space_after !== want.space_after)
            report("result mismatch", want, got);
      endfunction

      function int pending();
         return awaited.size();
      endfunction
   endclass
endpackage

module fit_policy_partition_allocator_unit_test;
   import fppa_pkg::*;
   import alloc_check_pkg::*;

   localparam logic [MODE_W-1:0]      MODE_SPARE    = 2'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_LO = 2'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNUSED_HI = 2'd3;

   localparam int DRAIN_CYCLES    = MAX_PARTS + 8;
   localparam int IDLE_LIMIT      = 4000;
   localparam int PHASES          = 9;
   localparam int ITEMS_PER_PHASE = 100;

   logic                   clock = 1'b0;
   logic                   reset;
   logic                   req_valid;
   logic                   req_stall;
   logic                   req_cmd;
   logic [PIDX_W-1:0]      req_partition_index;
   logic [SIZE_W-1:0]      req_size_kb;
   logic                   rsp_valid;
   logic                   rsp_stall;
   logic                   rsp_granted;
   logic [PIDX_W-1:0]      rsp_chosen_index;
   logic [SIZE_W-1:0]      rsp_space_before;
   logic [SIZE_W-1:0]      rsp_space_after;
   logic                   csr_write_enable;
   logic [CSR_INDEX_W-1:0] csr_index;
   logic [CSR_DATA_W-1:0]  csr_write_data;

   alloc_scoreboard sb = new();
   bit              req_quiet;
   bit              rsp_quiet;
   int              idle_cycles;

   fit_policy_partition_allocator_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_stall           (req_stall),
      .req_cmd             (req_cmd),
      .req_partition_index (req_partition_index),
      .req_size_kb         (req_size_kb),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_granted         (rsp_granted),
      .rsp_chosen_index    (rsp_chosen_index),
      .rsp_space_before    (rsp_space_before),
      .rsp_space_after     (rsp_space_after),
      .csr_write_enable    (csr_write_enable),
      .csr_index           (csr_index),
      .csr_write_data      (csr_write_data)
   );

   always #10 clock = ~clock;

   // mostly back to back, some short gaps, a few long ones
   function automatic int pick_gap(bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 65) return 0;
      if (r < 93) return $urandom_range(1, 3);
      return $urandom_range(8, 40);
   endfunction

   task automatic send_word(input logic cmd, input logic [PIDX_W-1:0] idx,
                            input logic [SIZE_W-1:0] kb);
      int gap;
      gap = pick_gap(req_quiet);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid           <= 1'b1;
      req_cmd             <= cmd;
      req_partition_index <= idx;
      req_size_kb         <= kb;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_word(cmd, idx, kb);
   endtask

   // hold the sender until every grant word is back, then let the block settle
   task automatic wait_idle(input int settle);
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending() != 0) @(posedge clock);
      repeat (settle) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] data);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= data;
      @(posedge clock);
      sb.set_register(idx, data);
   endtask

   task automatic apply_settings(input logic [MODE_W-1:0] mode, input logic [COUNT_W-1:0] count);
      logic [CSR_DATA_W-1:0] noise;
      logic [CSR_DATA_W-1:0] mode_word;
      wait_idle(DRAIN_CYCLES);
      noise = CSR_DATA_W'($urandom());
      write_register(CSR_UNUSED_LO, noise);
      noise = CSR_DATA_W'($urandom());
      write_register(CSR_UNUSED_HI, noise);
      // upper data bits carry junk; only the low bits select the policy
      mode_word = CSR_DATA_W'($urandom());
      mode_word[MODE_W-1:0] = mode;
      write_register(CSR_FIT_MODE, mode_word);
      write_register(CSR_PART_COUNT, count);
      csr_write_enable <= 1'b0;
   endtask

   // refills and requests aimed at the scanned partitions, near-fits and ties
   task automatic send_random_word();
      int                span;
      int                j;
      int                r;
      logic [PIDX_W-1:0] idx;
      logic [SIZE_W-1:0] kb;
      span = (int'(sb.count) > MAX_PARTS) ? MAX_PARTS : int'(sb.count);
      if (span == 0) span = MAX_PARTS;
      j   = $urandom_range(0, span - 1);
      idx = PIDX_W'($urandom());
      r   = $urandom_range(0, 99);
      if (r < 30) begin
         if ($urandom_range(0, 3) != 0) idx = j[PIDX_W-1:0];
         r = $urandom_range(0, 9);
         if (r < 3)      kb = sb.space[$urandom_range(0, span - 1)];
         else if (r < 6) kb = SIZE_W'($urandom_range(0, 1000));
         else if (r < 7) kb = 16'hFFFF;
         else            kb = SIZE_W'($urandom());
         send_word(CMD_LOAD, idx, kb);
      end else begin
         r = $urandom_range(0, 9);
         if (r < 3)      kb = SIZE_W'(sb.space[j] + $urandom_range(0, 2) - 1);
         else if (r < 4) kb = '0;
         else if (r < 7) kb = SIZE_W'($urandom_range(0, 300));
         else            kb = SIZE_W'($urandom());
         send_word(CMD_ALLOC, idx, kb);
      end
   endtask

   // result side: check every accepted word, stall at random
   initial begin
      int stall_left;
      stall_left = 0;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_result({rsp_granted, rsp_chosen_index, rsp_space_before, rsp_space_after});
         if (stall_left == 0) stall_left = pick_gap(rsp_quiet);
         rsp_stall <= (stall_left > 0);
         if (stall_left > 0) stall_left--;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write_enable) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   initial begin
      int                 phase;
      int                 item;
      int                 r;
      logic [SIZE_W-1:0]  fill_kb;
      logic [MODE_W-1:0]  phase_mode;
      logic [COUNT_W-1:0] phase_count;
      reset               <= 1'b1;
      req_valid           <= 1'b0;
      req_cmd             <= CMD_LOAD;
      req_partition_index <= '0;
      req_size_kb         <= '0;
      csr_write_enable    <= 1'b0;
      csr_index           <= CSR_FIT_MODE;
      csr_write_data      <= '0;
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: four partitions, each policy, ties, zero request, refusals
      apply_settings(MODE_FIRST, 8'd4);
      send_word(CMD_LOAD, 7'd0, 16'd100);
      send_word(CMD_LOAD, 7'd1, 16'd50);
      send_word(CMD_LOAD, 7'd2, 16'd100);
      send_word(CMD_LOAD, 7'd3, 16'hFFFF);
      send_word(CMD_ALLOC, 7'd127, 16'd60);
      send_word(CMD_ALLOC, 7'd0, 16'd0);
      apply_settings(MODE_BEST, 8'd4);
      send_word(CMD_ALLOC, 7'd0, 16'd45);
      send_word(CMD_ALLOC, 7'd0, 16'd100);
      send_word(CMD_LOAD, 7'd0, 16'd30);
      send_word(CMD_LOAD, 7'd1, 16'd30);
      send_word(CMD_ALLOC, 7'd3, 16'd30);
      apply_settings(MODE_WORST, 8'd4);
      send_word(CMD_ALLOC, 7'd0, 16'hFFFF);
      send_word(CMD_ALLOC, 7'd0, 16'd1);
      send_word(CMD_LOAD, 7'd2, 16'd29);
      send_word(CMD_ALLOC, 7'd0, 16'd2);
      send_word(CMD_ALLOC, 7'd0, 16'hFFFF);
      apply_settings(MODE_SPARE, 8'd4);
      send_word(CMD_ALLOC, 7'd0, 16'd1);
      apply_settings(MODE_FIRST, 8'd0);
      send_word(CMD_ALLOC, 7'd0, 16'd0);

      // load the whole table so that any count reads only written entries
      for (item = 0; item < MAX_PARTS; item++) begin
         r = $urandom_range(0, 9);
         if (r < 3)      fill_kb = SIZE_W'($urandom_range(0, 500));
         else if (r < 4) fill_kb = 16'hFFFF;
         else            fill_kb = SIZE_W'($urandom());
         send_word(CMD_LOAD, item[PIDX_W-1:0], fill_kb);
      end

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0:       begin phase_mode = MODE_FIRST; phase_count = 8'd128; end
            1:       begin phase_mode = MODE_BEST;  phase_count = 8'd128; end
            2:       begin phase_mode = MODE_WORST; phase_count = 8'd255; end
            3:       begin phase_mode = MODE_SPARE; phase_count = 8'd1;   end
            4:       begin phase_mode = MODE_BEST;  phase_count = 8'd16;  end
            5:       begin phase_mode = MODE_WORST; phase_count = 8'd129; end
            6:       begin phase_mode = MODE_FIRST; phase_count = 8'd0;   end
            7:       begin phase_mode = MODE_BEST;  phase_count = 8'd8;   end
            default: begin phase_mode = MODE_WORST; phase_count = 8'd32;  end
         endcase
         apply_settings(phase_mode, phase_count);
         req_quiet = (phase % 4 == 1) || (phase % 4 == 3);
         rsp_quiet = (phase % 4 == 2) || (phase % 4 == 3);
         for (item = 0; item < ITEMS_PER_PHASE; item++) begin
            if ($urandom_range(0, 79) == 0) wait_idle(0);
            send_random_word();
         end
      end

      wait_idle(DRAIN_CYCLES);
      if (sb.mismatches == 0 && sb.pending() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

[sim.f]
+incdir+design
design/fppa_pkg.sv
design/fppa_pick.sv
design/fit_policy_partition_allocator_unit.sv
design/fppa_checker.sv
bench/fit_policy_partition_allocator_unit_test.sv
